// ===== rtl/fqs_pkg.sv =====
// Shared types, sizes and helpers for the FIFO queue with search.
// No dependencies; imported by every module of the block.
`default_nettype none

package fqs_pkg;

  localparam int DEPTH = 16;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int VAL_W = 32;
  localparam int OUT_W = 48;

  typedef enum logic [1:0] {
    CMD_PUSH        = 2'd0,
    CMD_POP         = 2'd1,
    CMD_SEARCH      = 2'd2,
    CMD_COUNT_CLEAR = 2'd3
  } cmd_t;

  // control from the sequencer to the compare unit
  typedef struct packed {
    logic clear;
    logic en;
  } cmp_ctrl_t;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/fqs_cmp_unit.sv =====
// Shared compare-and-count unit: one ring entry compared per enabled cycle.
// Depends on fqs_pkg.
`default_nettype none

module fqs_cmp_unit
  import fqs_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire cmp_ctrl_t        ctrl,
  input  wire logic [VAL_W-1:0] entry,
  input  wire logic [VAL_W-1:0] key,
  output logic      [CNT_W-1:0] count
);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctrl.clear) begin
      count <= '0;
    end else if (ctrl.en && (entry == key)) begin
      count <= count + CNT_W'(1);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/fifo_queue_with_search_core.sv =====
// Top level of the FIFO queue with search: ring store, pointers, sequencer.
// Depends on fqs_pkg and fqs_cmp_unit.
//
// A 16-entry queue of signed 32-bit values taking one command per item:
// push, pop, search, or count-and-clear. Every item yields one result item.
// Push and pop pass the head-read and load states before the result is raised;
// search and count first pass the scan state, where the single compare unit walks
// the held entries one per cycle through the ring memory's one registered
// read port. The block takes one item at a time and is ready again the cycle
// after its result is loaded; a finished result waits in the output register
// while the next item is accepted.
`default_nettype none

module fifo_queue_with_search_core
  import fqs_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  // input items
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [VAL_W-1:0] s_tdata,  // [31:0] value
  input  wire logic [1:0]       s_tuser,  // [1:0] cmd
  // result items
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  // [0] is_empty, [5:1] length, [6] head_valid, [38:7] head_value,
  // [39] found, [44:40] match_count, [45] overflow, [47:46] zero
  output logic      [OUT_W-1:0] m_tdata
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HEAD_RD,
    ST_LOAD
  } state_t;

  state_t           state;
  cmd_t             cmd_q;
  logic [VAL_W-1:0] value_q;
  logic             ovf_q;
  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] tail;
  logic [CNT_W-1:0] count;
  logic [PTR_W-1:0] scan_ptr;
  logic [CNT_W-1:0] remaining;
  logic             rd_pend;

  logic [VAL_W-1:0] mem [DEPTH];
  logic [VAL_W-1:0] rd_data;
  logic [PTR_W-1:0] rd_addr;

  logic             in_acc;
  logic             full;
  cmd_t             in_cmd;
  cmp_ctrl_t        cmp_ctrl;
  logic [CNT_W-1:0] match_cnt;
  logic             head_valid;

  assign s_tready   = (state == ST_IDLE);
  assign in_acc     = s_tvalid && s_tready;
  assign in_cmd     = cmd_t'(s_tuser);
  assign full       = (count == CNT_W'(DEPTH));
  assign rd_addr    = (state == ST_SCAN) ? scan_ptr : head;
  assign head_valid = (count != '0);

  assign cmp_ctrl.clear = in_acc;
  assign cmp_ctrl.en    = rd_pend;

  // ring store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (in_acc && (in_cmd == CMD_PUSH) && !full) begin
      mem[tail] <= s_tdata;
    end
    rd_data <= mem[rd_addr];
  end

  fqs_cmp_unit u_cmp (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (cmp_ctrl),
    .entry (rd_data),
    .key   (value_q),
    .count (match_cnt)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      rd_pend   <= 1'b0;
      m_tvalid  <= 1'b0;
      cmd_q     <= CMD_PUSH;
      ovf_q     <= 1'b0;
      scan_ptr  <= '0;
      remaining <= '0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          rd_pend <= 1'b0;
          if (in_acc) begin
            cmd_q   <= in_cmd;
            value_q <= s_tdata;
            ovf_q   <= 1'b0;
            case (in_cmd)
              CMD_PUSH: begin
                if (full) begin
                  ovf_q <= 1'b1;
                end else begin
                  tail  <= ptr_next(tail);
                  count <= count + CNT_W'(1);
                end
                state <= ST_HEAD_RD;
              end
              CMD_POP: begin
                if (count != '0) begin
                  head  <= ptr_next(head);
                  count <= count - CNT_W'(1);
                end
                state <= ST_HEAD_RD;
              end
              default: begin
                scan_ptr  <= head;
                remaining <= count;
                state     <= ST_SCAN;
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (remaining != '0) begin
            scan_ptr  <= ptr_next(scan_ptr);
            remaining <= remaining - CNT_W'(1);
            rd_pend   <= 1'b1;
          end else begin
            rd_pend <= 1'b0;
          end
          // last compare has landed once nothing is left in flight
          if ((remaining == '0) && !rd_pend) begin
            if (cmd_q == CMD_COUNT_CLEAR) begin
              head  <= tail;
              count <= '0;
            end
            state <= ST_HEAD_RD;
          end
        end
        ST_HEAD_RD: begin
          state <= ST_LOAD;
        end
        ST_LOAD: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if ((state == ST_LOAD) && (!m_tvalid || m_tready)) begin
      m_tdata[0]     <= !head_valid;
      m_tdata[5:1]   <= count;
      m_tdata[6]     <= head_valid;
      m_tdata[38:7]  <= head_valid ? rd_data : '0;
      m_tdata[39]    <= (match_cnt != '0);
      m_tdata[44:40] <= match_cnt;
      m_tdata[45]    <= ovf_q;
      m_tdata[47:46] <= 2'b00;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_ring_consistent: assert property (@(posedge clk) disable iff (rst)
    (count != CNT_W'(DEPTH) && count != '0) |-> (PTR_W'(head + PTR_W'(count)) == tail))
    else $error("pointers disagree with entry count");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (match_cnt <= count))
    else $error("match count exceeds held entries");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && remaining == '0 && !rd_pend && cmd_q == CMD_COUNT_CLEAR)
    |=> (count == '0 && head == tail))
    else $error("count-and-clear left entries");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result changed while stalled");

endmodule

`default_nettype wire
